[design/lgs_pkg.sv]
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants, types and the controller command bundle for the
// toroidal life generation step block.
// ----------------------------------------------------------------------------
package lgs_pkg;

    localparam int CELL_W       = 64;  // cells in one stored row
    localparam int ROW_W        = 6;   // row index width on the ports
    localparam int CFG_W        = 7;   // configuration register width
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;
    localparam int MIN_DIM      = 3;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // configuration register indexes
    localparam logic CFG_ROWS_IDX = 1'b0;
    localparam logic CFG_COLS_IDX = 1'b1;

    // request kinds carried on s_tuser
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_RD_PREV,
        ST_ROW
    } lgs_state_t;

    typedef struct packed {
        logic             wr_en;       // write one row into the store
        logic             wr_from_step; // write data is the new row, not the load
        logic [ROW_W-1:0] wr_row;
        logic [ROW_W-1:0] rd_row;
        logic             cap_first;   // read data is old row 0
        logic             cap_prev;    // read data is old last row
        logic             advance;     // compute one row, emit it, shift window
        logic             last;        // current row is the final active row
    } lgs_cmd_t;

endpackage

[design/lgs_ctrl.sv]
// ----------------------------------------------------------------------------
// lgs_ctrl
// Sequencer for loads and generation steps: walks the rows, issues store
// reads one row ahead and paces the row computation against the output.
// ----------------------------------------------------------------------------
module lgs_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic                       s_tuser,
    input  logic [lgs_pkg::ROW_W-1:0]  load_row,
    input  logic [lgs_pkg::CFG_W-1:0]  rows_act,
    input  logic                       out_stall,
    output lgs_pkg::lgs_cmd_t          cmd
);
    import lgs_pkg::*;

    lgs_state_t       state_reg, state_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CFG_W-1:0] row_ext;
    logic [CFG_W-1:0] rd_target;
    logic             accept;
    logic             is_last;
    logic             adv;

    assign accept  = s_tvalid && s_tready;
    assign row_ext = CFG_W'(row_reg);
    assign is_last = (row_ext == rows_act - 7'd1);
    assign adv     = (state_reg == ST_ROW) && !out_stall;

    // next state
    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_tuser == ACT_STEP) begin
                    state_next = ST_RD_FIRST;
                end
            end
            ST_RD_FIRST: state_next = ST_RD_LAST;
            ST_RD_LAST:  state_next = ST_RD_PREV;
            ST_RD_PREV: begin
                state_next = ST_ROW;
                row_next   = '0;
            end
            ST_ROW: begin
                if (adv) begin
                    row_next = row_reg + 6'd1;
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
        end
    end

    // outputs
    always_comb begin
        cmd       = '0;
        s_tready  = 1'b0;
        rd_target = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (accept && s_tuser == ACT_LOAD) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_row = load_row;
                end
            end
            ST_RD_FIRST: rd_target = '0;
            ST_RD_LAST: begin
                rd_target     = rows_act - 7'd1;
                cmd.cap_first = 1'b1;
            end
            ST_RD_PREV: begin
                rd_target    = 7'd1;
                cmd.cap_prev = 1'b1;
            end
            ST_ROW: begin
                // fetch one row ahead; hold the fetch while the output stalls
                rd_target        = adv ? row_ext + 7'd2 : row_ext + 7'd1;
                cmd.advance      = adv;
                cmd.last         = is_last;
                cmd.wr_en        = adv;
                cmd.wr_from_step = 1'b1;
                cmd.wr_row       = row_reg;
            end
            default: ;
        endcase
        cmd.rd_row = (rd_target >= rows_act) ? '0 : rd_target[ROW_W-1:0];
    end

endmodule

[design/lgs_datapath.sv]
// ----------------------------------------------------------------------------
// lgs_datapath
// Row store with per-row valid bits, the three-row window, the next row
// logic and the output register.
// ----------------------------------------------------------------------------
module lgs_datapath #(
    parameter int MAX_ROWS = lgs_pkg::DEF_MAX_ROWS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lgs_pkg::lgs_cmd_t           cmd,
    input  logic [lgs_pkg::CELL_W-1:0]  load_cells,
    input  logic [lgs_pkg::CFG_W-1:0]   cols_act,
    output logic                        out_stall,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lgs_pkg::ROW_W-1:0]   out_row,
    output logic [lgs_pkg::CELL_W-1:0]  out_cells,
    output logic                        out_last
);
    import lgs_pkg::*;

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam logic [8:0] DEPTH = 9'(MAX_ROWS);

    logic [CELL_W-1:0]   mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] valid_reg;
    logic [CELL_W-1:0]   rd_mem_reg;
    logic                rd_vld_reg;
    logic [CELL_W-1:0]   rd_data;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic                wr_ok;
    logic [CELL_W-1:0]   wr_data;

    logic [CELL_W-1:0]   first_reg, prev_reg, cur_reg;
    logic [CELL_W-1:0]   down;
    logic [CELL_W-1:0]   nx;

    logic                m_tvalid_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic [CELL_W-1:0]   out_cells_reg;
    logic                out_last_reg;

    function automatic logic [CELL_W-1:0] west_of(input logic [CELL_W-1:0] w,
                                                  input logic [ROW_W-1:0] cm1,
                                                  input logic [CELL_W-1:0] m);
        west_of = ({w[CELL_W-2:0], 1'b0} | CELL_W'(w[cm1])) & m;
    endfunction

    function automatic logic [CELL_W-1:0] east_of(input logic [CELL_W-1:0] w,
                                                  input logic [ROW_W-1:0] cm1,
                                                  input logic [CELL_W-1:0] m);
        east_of = ({1'b0, w[CELL_W-1:1]} | (CELL_W'(w[0]) << cm1)) & m;
    endfunction

    function automatic logic [CELL_W-1:0] life_row(input logic [CELL_W-1:0] up_in,
                                                   input logic [CELL_W-1:0] cur_in,
                                                   input logic [CELL_W-1:0] dn_in,
                                                   input logic [CFG_W-1:0]  cols);
        logic [CELL_W-1:0] m, up, cu, dn;
        logic [CELL_W-1:0] nb [8];
        logic [ROW_W-1:0]  cm1;
        logic [3:0]        n;
        logic [CELL_W-1:0] res;
        for (int i = 0; i < CELL_W; i++) begin
            m[i] = (CFG_W'(i) < cols);
        end
        cm1   = ROW_W'(cols - 7'd1);
        up    = up_in & m;
        cu    = cur_in & m;
        dn    = dn_in & m;
        nb[0] = west_of(up, cm1, m);
        nb[1] = up;
        nb[2] = east_of(up, cm1, m);
        nb[3] = west_of(cu, cm1, m);
        nb[4] = east_of(cu, cm1, m);
        nb[5] = west_of(dn, cm1, m);
        nb[6] = dn;
        nb[7] = east_of(dn, cm1, m);
        for (int c = 0; c < CELL_W; c++) begin
            n = '0;
            for (int k = 0; k < 8; k++) begin
                n = n + 4'(nb[k][c]);
            end
            res[c] = (n == 4'd3) || (cu[c] && n == 4'd2);
        end
        life_row = res & m;
    endfunction

    assign wr_addr = AW'(cmd.wr_row);
    assign rd_addr = AW'(cmd.rd_row);
    assign wr_ok   = cmd.wr_en && ({3'b000, cmd.wr_row} < DEPTH);
    assign wr_data = cmd.wr_from_step ? nx : load_cells;
    assign rd_data = rd_vld_reg ? rd_mem_reg : '0;

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[wr_addr] <= wr_data;
        end
        rd_mem_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_ok) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[rd_addr];
        end
    end

    // the last row wraps to the saved old row 0
    assign down = cmd.last ? first_reg : rd_data;
    assign nx   = life_row(prev_reg, cur_reg, down, cols_act);

    always_ff @(posedge aclk) begin
        if (cmd.cap_first) begin
            first_reg <= rd_data;
            cur_reg   <= rd_data;
        end
        if (cmd.cap_prev) begin
            prev_reg <= rd_data;
        end
        if (cmd.advance) begin
            prev_reg <= cur_reg;
            cur_reg  <= down;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.advance) begin
            out_row_reg   <= cmd.wr_row;
            out_cells_reg <= nx;
            out_last_reg  <= cmd.last;
        end
    end

    assign out_stall = m_tvalid_reg && !m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign out_row   = out_row_reg;
    assign out_cells = out_cells_reg;
    assign out_last  = out_last_reg;

endmodule

[design/life_generation_step_top.sv]
// ----------------------------------------------------------------------------
// life_generation_step_top
// Toroidal Conway life engine with row loads and in-place generation steps.
// ----------------------------------------------------------------------------
// A load request writes one row and returns nothing. A step request first
// reads old row 0, the old last row and old row 1 from the single-read-port
// row store, then one row is computed, written back and emitted per cycle
// while the output does not stall, with the next row read ahead through the
// registered store read. Output back-pressure holds the step while the
// output stalls. The store comes out of reset all dead through per-row valid
// bits, so no clearing pass is needed and requests are taken at once.
module life_generation_step_top #(
    parameter int MAX_ROWS = lgs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lgs_pkg::DEF_MAX_COLS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [71:0]               s_tdata,   // row_index[5:0], row_cells[69:6], zero
    input  logic                      s_tuser,   // action
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [71:0]               m_tdata,   // out_row[5:0], out_cells[69:6], zero
    output logic                      m_tlast,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_index,
    input  logic [lgs_pkg::CFG_W-1:0] cfg_wdata
);
    import lgs_pkg::*;

    localparam int ROW_TOP = (MAX_ROWS < 64) ? MAX_ROWS : 64;
    localparam logic [CFG_W-1:0] ROWS_HI = CFG_W'(ROW_TOP);
    localparam logic [CFG_W-1:0] COLS_HI = CFG_W'(MAX_COLS);
    localparam logic [CFG_W-1:0] DIM_LO  = CFG_W'(MIN_DIM);

    logic [CFG_W-1:0]  rows_used_reg, cols_used_reg;
    logic [CFG_W-1:0]  rows_act, cols_act;
    lgs_cmd_t          cmd;
    logic              out_stall;
    logic [ROW_W-1:0]  out_row;
    logic [CELL_W-1:0] out_cells;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_used_reg <= CFG_RESET;
            cols_used_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_ROWS_IDX) begin
                rows_used_reg <= cfg_wdata;
            end else begin
                cols_used_reg <= cfg_wdata;
            end
        end
    end

    // saturate the wrap boundaries to the supported range
    always_comb begin
        rows_act = rows_used_reg;
        if (rows_act < DIM_LO) rows_act = DIM_LO;
        if (rows_act > ROWS_HI) rows_act = ROWS_HI;
        cols_act = cols_used_reg;
        if (cols_act < DIM_LO) cols_act = DIM_LO;
        if (cols_act > COLS_HI) cols_act = COLS_HI;
    end

    lgs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .load_row  (s_tdata[ROW_W-1:0]),
        .rows_act  (rows_act),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    lgs_datapath #(
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .load_cells (s_tdata[ROW_W +: CELL_W]),
        .cols_act   (cols_act),
        .out_stall  (out_stall),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_row    (out_row),
        .out_cells  (out_cells),
        .out_last   (m_tlast)
    );

    assign m_tdata = {2'b00, out_cells, out_row};

endmodule
